/* design/cau_pkg.sv */
// Shared types, operation codes and saturation helpers of the complex arithmetic unit.
package cau_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int NUM_W       = PROD_W + FRAC_W;
    localparam int DIV_STEPS   = NUM_W;
    localparam int ISQ_STEPS   = DATA_W;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_CONJ = 3'd3;
    localparam logic [2:0] MODE_DIV  = 3'd4;
    localparam logic [2:0] MODE_SQRT = 3'd5;

    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic                     div_zero;
        logic                     saturated;
    } t_out;

    typedef struct packed {
        logic long_op;
        t_in  item;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              clamp;
    } t_sat;

    // Clamp a signed value of up to 65 bits to the result range.
    function automatic t_sat sat_signed(input logic signed [PROD_W:0] v);
        t_sat r;
        if (v > $signed({{(PROD_W-DATA_W+2){1'b0}}, VAL_MAX[DATA_W-2:0]})) begin
            r.value = VAL_MAX;
            r.clamp = 1'b1;
        end else if (v < -$signed({{(PROD_W-DATA_W+1){1'b0}}, VAL_MIN})) begin
            r.value = VAL_MIN;
            r.clamp = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
            r.clamp = 1'b0;
        end
        return r;
    endfunction

    // Clamp a sign and magnitude pair to the result range.
    function automatic t_sat sat_mag(input logic neg, input logic [NUM_W-1:0] mag);
        t_sat r;
        if (!neg) begin
            if (mag > NUM_W'(VAL_MAX)) begin
                r.value = VAL_MAX;
                r.clamp = 1'b1;
            end else begin
                r.value = mag[DATA_W-1:0];
                r.clamp = 1'b0;
            end
        end else begin
            if (mag > NUM_W'(VAL_MIN)) begin
                r.value = VAL_MIN;
                r.clamp = 1'b1;
            end else begin
                r.value = DATA_W'(0) - mag[DATA_W-1:0];
                r.clamp = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

/* design/complex_arithmetic_unit.sv */
// Top level of the complex arithmetic unit: front end, command queue and back end.
//
// Complex arithmetic on signed Q16.16 parts: add, subtract, multiply, conjugate,
// divide and principal square root, every result part saturated with a flag. Raise
// start with a command word on i_item; the word is taken on a rising edge where start
// is high and busy is low. Each result word appears on o_result for exactly one
// cycle, marked by o_done, and cannot be held off, so capture it then. Results leave
// in command order. Add, subtract, multiply, conjugate and the unused codes go down a
// two-stage pipeline and sustain one word per cycle while the iterative unit is idle.
// Divide and square root run in one shared iterative unit that retires one quotient
// bit or one root bit pair per cycle: a divide keeps it for its 80 quotient bits, a
// square root for two 32-step roots and an 80-step quotient. A four-word queue sits
// in front of the back end, so busy rises only when that queue plus the word entering
// it fills behind a long operation; short words queued behind a long one wait for it.
module complex_arithmetic_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  cau_pkg::t_in  i_item,
    output logic          busy,
    output logic          o_done,
    output cau_pkg::t_out o_result
);

    logic                     w_push, w_pop, w_q_valid;
    cau_pkg::t_cmd            w_cmd, w_head;
    logic [cau_pkg::QPTR_W:0] w_count;

    // accept and tag words
    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_count (w_count),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    // hold words until the back end is free
    cau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_head),
        .o_count (w_count)
    );

    // carry out the operation and drive the result strobe
    cau_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_head  (w_head),
        .o_pop     (w_pop),
        .o_done    (o_done),
        .o_res     (o_result)
    );

endmodule

/* design/cau_front.sv */
// Front end: take command words, tag long operations and push them into the queue.
module cau_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  cau_pkg::t_in             i_item,
    input  logic [cau_pkg::QPTR_W:0] i_count,
    output logic                     o_busy,
    output logic                     o_push,
    output cau_pkg::t_cmd            o_cmd
);

    logic          r_valid;
    cau_pkg::t_cmd r_cmd;
    cau_pkg::t_cmd n_cmd;
    logic          w_take;

    // hold off while the queue cannot absorb the word in flight plus one more
    assign o_busy = ((cau_pkg::QPTR_W+2)'(i_count) + (cau_pkg::QPTR_W+2)'(r_valid))
                    >= (cau_pkg::QPTR_W+2)'(cau_pkg::QUEUE_DEPTH);
    assign w_take = i_start && !o_busy;

    always_comb begin
        n_cmd.item    = i_item;
        n_cmd.long_op = (i_item.mode == cau_pkg::MODE_DIV) ||
                        (i_item.mode == cau_pkg::MODE_SQRT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_take;
        end
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push = r_valid;
    assign o_cmd  = r_cmd;

endmodule

/* design/cau_queue.sv */
// Short command queue between the front end and the back end.
module cau_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  cau_pkg::t_cmd            i_cmd,
    input  logic                     i_pop,
    output logic                     o_valid,
    output cau_pkg::t_cmd            o_head,
    output logic [cau_pkg::QPTR_W:0] o_count
);

    cau_pkg::t_cmd               r_mem [cau_pkg::QUEUE_DEPTH];
    logic [cau_pkg::QPTR_W-1:0]  r_wr;
    logic [cau_pkg::QPTR_W-1:0]  r_rd;
    logic [cau_pkg::QPTR_W:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

/* design/cau_serial.sv */
// Iterative unit for divide and square root: restoring divider lanes and a bit-pair root.
module cau_serial (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cau_pkg::t_in  i_item,
    output logic          o_busy,
    output logic          o_done,
    output cau_pkg::t_out o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SUM, S_ISQ1, S_LD2, S_ISQ2, S_LD3, S_DIV, S_FIN
    } t_state;

    localparam int PW = cau_pkg::PROD_W;
    localparam int NW = cau_pkg::NUM_W;
    localparam int DW = cau_pkg::DATA_W;
    localparam int FW = cau_pkg::FRAC_W;
    localparam int RW = DW + 4;

    t_state                r_state;
    logic                  r_div;
    logic signed [DW-1:0]  r_ar, r_ai, r_br, r_bi;
    logic signed [PW-1:0]  r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic [6:0]            r_cnt;
    logic [NW-1:0]         r_n0, r_n1;
    logic [PW-1:0]         r_r0, r_r1, r_den;
    logic                  r_neg0, r_neg1;
    logic [PW-1:0]         r_x;
    logic [RW-1:0]         r_rem;
    logic [DW-1:0]         r_root;
    logic                  r_done;
    cau_pkg::t_out         r_res;

    logic [PW:0]           w_rs0, w_rs1, w_sb0, w_sb1;
    logic                  w_ge0, w_ge1;
    logic [RW-1:0]         w_rem2, w_trial, w_rsub;
    logic                  w_rge;
    logic [DW-1:0]         w_abs_ar, w_abs_ai;
    logic signed [PW:0]    w_num_re, w_num_im;
    logic [PW:0]           w_mag_re, w_mag_im;
    logic [PW-1:0]         w_den, w_ssq;
    logic [DW+1:0]         w_t;
    cau_pkg::t_sat         w_fre, w_fim;
    cau_pkg::t_out         w_dz;

    // divider lanes: shift in one numerator bit, subtract where it fits
    assign w_rs0 = {r_r0, r_n0[NW-1]};
    assign w_rs1 = {r_r1, r_n1[NW-1]};
    assign w_ge0 = w_rs0 >= {1'b0, r_den};
    assign w_ge1 = w_rs1 >= {1'b0, r_den};
    assign w_sb0 = w_rs0 - {1'b0, r_den};
    assign w_sb1 = w_rs1 - {1'b0, r_den};

    // root: bring down two bits, try root*4+1
    assign w_rem2  = {r_rem[RW-3:0], r_x[PW-1:PW-2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_rge   = w_rem2 >= w_trial;
    assign w_rsub  = w_rem2 - w_trial;

    assign w_abs_ar = r_ar[DW-1] ? DW'(-r_ar) : DW'(r_ar);
    assign w_abs_ai = r_ai[DW-1] ? DW'(-r_ai) : DW'(r_ai);
    assign w_num_re = (PW+1)'(r_p0) + (PW+1)'(r_p1);
    assign w_num_im = (PW+1)'(r_p2) - (PW+1)'(r_p3);
    assign w_mag_re = w_num_re[PW] ? (PW+1)'(-w_num_re) : (PW+1)'(w_num_re);
    assign w_mag_im = w_num_im[PW] ? (PW+1)'(-w_num_im) : (PW+1)'(w_num_im);
    assign w_den    = PW'(r_p4) + PW'(r_p5);
    assign w_ssq    = PW'(r_p0) + PW'(r_p1);
    assign w_t      = (DW+2)'(r_root) + (DW+2)'(w_abs_ar);

    always_comb begin
        w_dz.div_zero  = 1'b1;
        w_dz.res_re    = (r_ar == '0) ? '0 : (r_ar[DW-1] ? cau_pkg::VAL_MIN : cau_pkg::VAL_MAX);
        w_dz.res_im    = (r_ai == '0) ? '0 : (r_ai[DW-1] ? cau_pkg::VAL_MIN : cau_pkg::VAL_MAX);
        w_dz.saturated = (r_ar != '0) || (r_ai != '0);
    end

    always_comb begin
        if (r_div) begin
            w_fre = cau_pkg::sat_mag(r_neg0, r_n0);
            w_fim = cau_pkg::sat_mag(r_neg1, r_n1);
        end else if (!r_ar[DW-1]) begin
            w_fre = cau_pkg::sat_mag(1'b0, NW'(r_root));
            w_fim = cau_pkg::sat_mag(r_ai[DW-1], r_n0);
        end else begin
            w_fre = cau_pkg::sat_mag(1'b0, r_n0);
            w_fim = cau_pkg::sat_mag(r_ai[DW-1], NW'(r_root));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_div   <= (i_item.mode == cau_pkg::MODE_DIV);
                        r_ar    <= i_item.a_re;
                        r_ai    <= i_item.a_im;
                        // square root squares a: feed a in place of b
                        r_br    <= (i_item.mode == cau_pkg::MODE_DIV) ? i_item.b_re : i_item.a_re;
                        r_bi    <= (i_item.mode == cau_pkg::MODE_DIV) ? i_item.b_im : i_item.a_im;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p0    <= PW'(r_ar) * PW'(r_br);
                    r_p1    <= PW'(r_ai) * PW'(r_bi);
                    r_p2    <= PW'(r_ai) * PW'(r_br);
                    r_p3    <= PW'(r_ar) * PW'(r_bi);
                    r_p4    <= PW'(r_br) * PW'(r_br);
                    r_p5    <= PW'(r_bi) * PW'(r_bi);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_cnt <= '0;
                    if (r_div) begin
                        if (w_den == '0) begin
                            r_res   <= w_dz;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_den   <= w_den;
                            r_n0    <= {w_mag_re[PW-1:0], {FW{1'b0}}};
                            r_n1    <= {w_mag_im[PW-1:0], {FW{1'b0}}};
                            r_neg0  <= w_num_re[PW];
                            r_neg1  <= w_num_im[PW];
                            r_r0    <= '0;
                            r_r1    <= '0;
                            r_state <= S_DIV;
                        end
                    end else if ((r_ar == '0) && (r_ai == '0)) begin
                        r_res   <= '0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_x     <= w_ssq;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_state <= S_ISQ1;
                    end
                end
                S_ISQ1, S_ISQ2: begin
                    r_x    <= {r_x[PW-3:0], 2'b00};
                    r_rem  <= w_rge ? w_rsub : w_rem2;
                    r_root <= {r_root[DW-2:0], w_rge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 7'(cau_pkg::ISQ_STEPS - 1)) begin
                        r_state <= (r_state == S_ISQ1) ? S_LD2 : S_LD3;
                    end
                end
                S_LD2: begin
                    r_x     <= PW'(w_t) << (FW - 1);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_ISQ2;
                end
                S_LD3: begin
                    r_n0    <= NW'({w_abs_ai, {FW{1'b0}}});
                    r_den   <= PW'({r_root, 1'b0});
                    r_neg0  <= r_ai[DW-1];
                    r_r0    <= '0;
                    r_r1    <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_r0  <= w_ge0 ? w_sb0[PW-1:0] : w_rs0[PW-1:0];
                    r_r1  <= w_ge1 ? w_sb1[PW-1:0] : w_rs1[PW-1:0];
                    r_n0  <= {r_n0[NW-2:0], w_ge0};
                    r_n1  <= {r_n1[NW-2:0], w_ge1};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 7'(cau_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_res.res_re    <= w_fre.value;
                    r_res.res_im    <= w_fim.value;
                    r_res.div_zero  <= 1'b0;
                    r_res.saturated <= w_fre.clamp | w_fim.clamp;
                    r_done          <= 1'b1;
                    r_state         <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* design/cau_back.sv */
// Back end: two-stage pipeline for short operations beside the iterative unit.
module cau_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  cau_pkg::t_cmd i_q_head,
    output logic          o_pop,
    output logic          o_done,
    output cau_pkg::t_out o_res
);

    localparam int PW = cau_pkg::PROD_W;
    localparam int DW = cau_pkg::DATA_W;

    logic                 w_ser_busy, w_ser_done, w_ser_start, w_fast_go;
    cau_pkg::t_out        w_ser_res;
    logic                 r_s1_valid;
    logic [2:0]           r_s1_mode;
    logic signed [DW-1:0] r_ar, r_ai, r_br, r_bi;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ir, r_p_ri;
    logic signed [PW:0]   w_mre, w_mim;
    cau_pkg::t_sat        w_sre, w_sim;
    cau_pkg::t_out        n_res;
    logic                 r_done;
    cau_pkg::t_out        r_res;

    // take the head only while the iterative unit is free, so results leave in order
    assign o_pop       = i_q_valid && !w_ser_busy;
    assign w_ser_start = o_pop && i_q_head.long_op;
    assign w_fast_go   = o_pop && !i_q_head.long_op;

    cau_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ser_start),
        .i_item  (i_q_head.item),
        .o_busy  (w_ser_busy),
        .o_done  (w_ser_done),
        .o_res   (w_ser_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_fast_go;
        end
        if (w_fast_go) begin
            r_s1_mode <= i_q_head.item.mode;
            r_ar      <= i_q_head.item.a_re;
            r_ai      <= i_q_head.item.a_im;
            r_br      <= i_q_head.item.b_re;
            r_bi      <= i_q_head.item.b_im;
            r_p_rr    <= PW'(i_q_head.item.a_re) * PW'(i_q_head.item.b_re);
            r_p_ii    <= PW'(i_q_head.item.a_im) * PW'(i_q_head.item.b_im);
            r_p_ir    <= PW'(i_q_head.item.a_im) * PW'(i_q_head.item.b_re);
            r_p_ri    <= PW'(i_q_head.item.a_re) * PW'(i_q_head.item.b_im);
        end
    end

    // floor shift of the exact product sums
    assign w_mre = ((PW+1)'(r_p_rr) - (PW+1)'(r_p_ii)) >>> cau_pkg::FRAC_W;
    assign w_mim = ((PW+1)'(r_p_ir) + (PW+1)'(r_p_ri)) >>> cau_pkg::FRAC_W;

    always_comb begin
        case (r_s1_mode)
            cau_pkg::MODE_ADD: begin
                w_sre = cau_pkg::sat_signed((PW+1)'(r_ar) + (PW+1)'(r_br));
                w_sim = cau_pkg::sat_signed((PW+1)'(r_ai) + (PW+1)'(r_bi));
            end
            cau_pkg::MODE_SUB: begin
                w_sre = cau_pkg::sat_signed((PW+1)'(r_ar) - (PW+1)'(r_br));
                w_sim = cau_pkg::sat_signed((PW+1)'(r_ai) - (PW+1)'(r_bi));
            end
            cau_pkg::MODE_MUL: begin
                w_sre = cau_pkg::sat_signed(w_mre);
                w_sim = cau_pkg::sat_signed(w_mim);
            end
            cau_pkg::MODE_CONJ: begin
                w_sre = cau_pkg::sat_signed((PW+1)'(r_ar));
                w_sim = cau_pkg::sat_signed(-((PW+1)'(r_ai)));
            end
            default: begin
                w_sre = '0;
                w_sim = '0;
            end
        endcase
        n_res.res_re    = w_sre.value;
        n_res.res_im    = w_sim.value;
        n_res.div_zero  = 1'b0;
        n_res.saturated = w_sre.clamp | w_sim.clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_valid | w_ser_done;
        end
        r_res <= w_ser_done ? w_ser_res : n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ser_done |-> !r_s1_valid)
        else $error("iterative and pipeline results in the same cycle");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !w_ser_busy)
        else $error("command taken while iterative unit busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ser_start |=> w_ser_busy)
        else $error("iterative unit did not start");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_res.div_zero && !r_res.saturated) |->
        (r_res.res_re == '0 && r_res.res_im == '0))
        else $error("zero-divisor word without clamp is not zero");
`endif

endmodule
